FILE: rtl/core/irs_pkg.sv
// shared types and constants of the image resize unit
`default_nettype none
package irs_pkg;

  localparam int unsigned MaxSrcWidth    = 64;
  localparam int unsigned MaxSrcHeight   = 64;
  localparam int unsigned MaxDstSize     = 1024;
  localparam int unsigned WeightFracBits = 8;

  // divider operand widths
  localparam int unsigned DenW = 11;
  localparam int unsigned NumW = (11 + WeightFracBits > 17) ? 11 + WeightFracBits : 17;

  localparam logic [1:0] MethodNearest  = 2'd1;
  localparam logic [1:0] MethodBilinear = 2'd2;
  localparam logic [1:0] ColorGray      = 2'd0;
  localparam logic [1:0] ColorRgb       = 2'd1;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_DST_WIDTH     = 3'd2,
    REG_DST_HEIGHT    = 3'd3,
    REG_KEEP_ASPECT   = 3'd4,
    REG_RESIZE_METHOD = 3'd5,
    REG_COLOR_MODE    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DIV_H = 3'd0,
    DIV_X = 3'd1,
    DIV_Y = 3'd2,
    DIV_A = 3'd3,
    DIV_B = 3'd4
  } div_sel_e;

  typedef struct packed {
    logic [6:0]  src_width;
    logic [6:0]  src_height;
    logic [10:0] dst_width;
    logic [10:0] dst_height;
    logic        keep_aspect;
    logic [1:0]  resize_method;
    logic [1:0]  color_mode;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     div_start;
    logic     div_latch;
    div_sel_e div_sel;
    logic     eval;
    logic     prep;
    logic     rd_en;
    logic [1:0] rd_idx;
    logic     acc_en;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic run;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/image_resize_nearest_bilinear_unit.sv
// top level of the nearest neighbour and bilinear image resize unit
//
// A word with command 0 loads one source pixel into the frame store in the
// cycle it is taken, so loads run at one per cycle while busy is low. A word
// with command 1 asks for one destination pixel: busy is high after the word
// is taken, and the result is shown in the cycle busy falls, so no new word
// is taken before the last request has finished. The time is set by the
// shared divider, used up to five times a request (height with keep_aspect,
// then x, y and two weights), and by four frame store reads on its single
// port; the divisions after the height and the reads happen only for a pixel
// inside the destination with a valid method and colour mode. Each result is
// shown for one cycle on res_valid_o and cannot be held off. Frame store
// entries read before being loaded give undefined pixel values.
`default_nettype none
module image_resize_nearest_bilinear_unit import irs_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MaxSrcWidth,
  parameter int unsigned MAX_SRC_HEIGHT = MaxSrcHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        command_i,
  input  wire logic [9:0]  col_i,
  input  wire logic [9:0]  row_i,
  input  wire logic [7:0]  pix_ch0_i,
  input  wire logic [7:0]  pix_ch1_i,
  input  wire logic [7:0]  pix_ch2_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i,
  output logic             res_valid_o,
  output logic [9:0]       dest_col_o,
  output logic [9:0]       dest_row_o,
  output logic [7:0]       out_ch0_o,
  output logic [7:0]       out_ch1_o,
  output logic [7:0]       out_ch2_o,
  output logic             outside_o
);

  localparam int unsigned Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  cfg_t             cfg_q, cfg_d;
  cmd_t             cmd;
  sts_t             sts;
  logic             take, load_we, busy_int;
  logic [AddrW-1:0] load_addr, rd_addr, ram_addr;
  logic [23:0]      rd_data;

  assign cfg_ready_o = 1'b1;
  assign busy        = busy_int;
  assign take        = start && !busy_int;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SRC_WIDTH:     cfg_d.src_width     = cfg_data_i[6:0];
        REG_SRC_HEIGHT:    cfg_d.src_height    = cfg_data_i[6:0];
        REG_DST_WIDTH:     cfg_d.dst_width     = cfg_data_i;
        REG_DST_HEIGHT:    cfg_d.dst_height    = cfg_data_i;
        REG_KEEP_ASPECT:   cfg_d.keep_aspect   = cfg_data_i[0];
        REG_RESIZE_METHOD: cfg_d.resize_method = cfg_data_i[1:0];
        REG_COLOR_MODE:    cfg_d.color_mode    = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_width     <= 7'd64;
      cfg_q.src_height    <= 7'd64;
      cfg_q.dst_width     <= 11'd64;
      cfg_q.dst_height    <= 11'd64;
      cfg_q.keep_aspect   <= 1'b0;
      cfg_q.resize_method <= MethodNearest;
      cfg_q.color_mode    <= ColorRgb;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // source pixel load
  assign load_we   = take && !command_i && 32'(col_i) < MAX_SRC_WIDTH &&
                     32'(row_i) < MAX_SRC_HEIGHT;
  assign load_addr = AddrW'(AddrW'(row_i) * AddrW'(MAX_SRC_WIDTH) + AddrW'(col_i));
  assign ram_addr  = load_we ? load_addr : rd_addr;

  irs_ram #(
    .WIDTH (24),
    .DEPTH (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .addr_i  (ram_addr),
    .wdata_i ({pix_ch2_i, pix_ch1_i, pix_ch0_i}),
    .rdata_o (rd_data)
  );

  irs_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (take && command_i),
    .keep_aspect_i (cfg_q.keep_aspect),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .busy_o        (busy_int)
  );

  irs_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .col_i       (col_i),
    .row_i       (row_i),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid_o),
    .dest_col_o  (dest_col_o),
    .dest_row_o  (dest_row_o),
    .out_ch0_o   (out_ch0_o),
    .out_ch1_o   (out_ch1_o),
    .out_ch2_o   (out_ch2_o),
    .outside_o   (outside_o)
  );

endmodule
`default_nettype wire

FILE: rtl/core/irs_ram.sv
// generic single port ram with registered read
`default_nettype none
module irs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/core/irs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module irs_div import irs_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic      [NumW-1:0] quo_o,
  output logic      [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            run_q, run_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] n_q, n_d;
  logic [DenW-1:0] r_q, r_d, d_q, d_d;
  logic [DenW:0]   t;
  logic            sub_ok;

  always_comb begin
    t      = {r_q, n_q[NumW-1]};
    sub_ok = t >= {1'b0, d_q};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    r_d    = r_q;
    d_d    = d_q;
    if (start_i) begin
      n_d   = num_i;
      r_d   = '0;
      d_d   = den_i;
      cnt_d = CntW'(NumW);
      run_d = 1'b1;
    end else if (run_q) begin
      n_d   = {n_q[NumW-2:0], sub_ok};
      r_d   = sub_ok ? DenW'(t - {1'b0, d_q}) : t[DenW-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quo_o  = n_q;
  assign rem_o  = r_q;

endmodule
`default_nettype wire

FILE: rtl/core/irs_ctrl.sv
// request sequencer of the image resize unit
`default_nettype none
module irs_ctrl import irs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_i,
  input  wire logic keep_aspect_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_DIVH = 10'b00_0000_0010,
    ST_EVAL = 10'b00_0000_0100,
    ST_DIVX = 10'b00_0000_1000,
    ST_DIVY = 10'b00_0001_0000,
    ST_DIVA = 10'b00_0010_0000,
    ST_DIVB = 10'b00_0100_0000,
    ST_PREP = 10'b00_1000_0000,
    ST_READ = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  state_e     state_q, state_d, div_next;
  logic       started_q, started_d, in_div;
  logic [2:0] cnt_q, cnt_d;

  always_comb begin
    state_d   = state_q;
    started_d = started_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    in_div    = 1'b0;
    div_next  = ST_IDLE;
    cmd_o.div_sel = DIV_H;
    case (state_q)
      ST_IDLE: begin
        if (req_i) begin
          cmd_o.capture = 1'b1;
          state_d = keep_aspect_i ? ST_DIVH : ST_EVAL;
        end
      end
      ST_DIVH: begin
        in_div = 1'b1; cmd_o.div_sel = DIV_H; div_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d = sts_i.run ? ST_DIVX : ST_FIN;
      end
      ST_DIVX: begin
        in_div = 1'b1; cmd_o.div_sel = DIV_X; div_next = ST_DIVY;
      end
      ST_DIVY: begin
        in_div = 1'b1; cmd_o.div_sel = DIV_Y; div_next = ST_DIVA;
      end
      ST_DIVA: begin
        in_div = 1'b1; cmd_o.div_sel = DIV_A; div_next = ST_DIVB;
      end
      ST_DIVB: begin
        in_div = 1'b1; cmd_o.div_sel = DIV_B; div_next = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d   = '0;
        state_d = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en  = cnt_q != 3'd4;
        cmd_o.rd_idx = cnt_q[1:0];
        cmd_o.acc_en = cnt_q != 3'd0;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (in_div) begin
      if (!started_q) begin
        cmd_o.div_start = 1'b1;
        started_d = 1'b1;
      end else if (sts_i.div_done) begin
        cmd_o.div_latch = 1'b1;
        started_d = 1'b0;
        state_d   = div_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      started_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
    end
  end

  assign busy_o = state_q != ST_IDLE;

endmodule
`default_nettype wire

FILE: rtl/core/irs_dp.sv
// datapath: coordinate division, neighbour selection and weighted sum
`default_nettype none
module irs_dp import irs_pkg::*; #(
  parameter int unsigned MAX_SRC_WIDTH  = MaxSrcWidth,
  parameter int unsigned MAX_SRC_HEIGHT = MaxSrcHeight
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire cmd_t        cmd_i,
  output sts_t             sts_o,
  input  wire logic [9:0]  col_i,
  input  wire logic [9:0]  row_i,
  output logic [$clog2(MAX_SRC_WIDTH*MAX_SRC_HEIGHT)-1:0] rd_addr_o,
  input  wire logic [23:0] rd_data_i,
  output logic             res_valid_o,
  output logic [9:0]       dest_col_o,
  output logic [9:0]       dest_row_o,
  output logic [7:0]       out_ch0_o,
  output logic [7:0]       out_ch1_o,
  output logic [7:0]       out_ch2_o,
  output logic             outside_o
);

  localparam int unsigned AddrW = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int unsigned XW    = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_SRC_HEIGHT);
  localparam int unsigned Wf    = WeightFracBits;
  localparam int unsigned PW    = 2 * Wf + 1;
  localparam int unsigned AccW  = 2 * Wf + 8;
  localparam logic [Wf:0] One   = (Wf+1)'(1) << Wf;

  function automatic logic [NumW-1:0] near_idx(logic [NumW-1:0] q, logic [DenW-1:0] r,
                                              logic [DenW-1:0] d, logic [NumW-1:0] lim);
    logic [DenW:0]   t;
    logic [NumW-1:0] v;
    t = {r, 1'b0};
    v = q;
    if (t > {1'b0, d} || (t == {1'b0, d} && q[0])) begin
      v = q + NumW'(1);
    end
    if (v > lim - NumW'(1)) begin
      v = lim - NumW'(1);
    end
    return v;
  endfunction

  logic [6:0]      sw, sh;
  logic [10:0]     dw, dh_cfg, dh_eff, ynum, yden;
  logic            outside, run;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic            div_done;
  logic [NumW-1:0] quo;
  logic [DenW-1:0] rem;

  logic [9:0]      col_q, row_q;
  logic [10:0]     dh_q;
  logic [NumW-1:0] qx_q, qy_q;
  logic [DenW-1:0] rx_q, ry_q;
  logic [Wf-1:0]   a_q, b_q, wa_q, wb_q;
  logic [XW-1:0]   x0_q, x1_q;
  logic [YW-1:0]   y0_q, y1_q;
  logic [PW-1:0]   w_q;
  logic [AccW-1:0] acc_q [3];
  logic            run_q, outside_q;
  logic            res_valid_q;
  logic [7:0]      ch_q [3];
  logic [9:0]      dest_col_q, dest_row_q;
  logic            res_outside_q;

  logic [NumW-1:0] sw_lim, sh_lim, x0, x1, y0, y1, x1c, y1c;
  logic [Wf-1:0]   wa, wb;
  logic [Wf:0]     wx, wy;
  logic [XW-1:0]   xs;
  logic [YW-1:0]   ys;

  // saturated sizes
  always_comb begin
    sw = cfg_i.src_width;
    if (cfg_i.src_width == 7'd0) sw = 7'd1;
    else if (32'(cfg_i.src_width) > MAX_SRC_WIDTH) sw = 7'(MAX_SRC_WIDTH);
    sh = cfg_i.src_height;
    if (cfg_i.src_height == 7'd0) sh = 7'd1;
    else if (32'(cfg_i.src_height) > MAX_SRC_HEIGHT) sh = 7'(MAX_SRC_HEIGHT);
    dw = cfg_i.dst_width;
    if (cfg_i.dst_width == 11'd0) dw = 11'd1;
    else if (32'(cfg_i.dst_width) > MaxDstSize) dw = 11'(MaxDstSize);
    dh_cfg = cfg_i.dst_height;
    if (cfg_i.dst_height == 11'd0) dh_cfg = 11'd1;
    else if (32'(cfg_i.dst_height) > MaxDstSize) dh_cfg = 11'(MaxDstSize);
    dh_eff  = cfg_i.keep_aspect ? dh_q : dh_cfg;
    ynum    = cfg_i.keep_aspect ? 11'(sw) : 11'(sh);
    yden    = cfg_i.keep_aspect ? dw : dh_cfg;
    outside = {1'b0, col_q} >= dw || {1'b0, row_q} >= dh_eff;
    run     = !outside && cfg_i.color_mode <= ColorRgb &&
              (cfg_i.resize_method == MethodNearest ||
               cfg_i.resize_method == MethodBilinear);
  end

  // divider operands
  always_comb begin
    case (cmd_i.div_sel)
      DIV_H: begin
        num = NumW'(NumW'(dw) * NumW'(sh));
        den = DenW'(sw);
      end
      DIV_X: begin
        num = NumW'(NumW'(col_q) * NumW'(sw));
        den = dw;
      end
      DIV_Y: begin
        num = NumW'(NumW'(row_q) * NumW'(ynum));
        den = yden;
      end
      DIV_A: begin
        num = NumW'(rx_q) << Wf;
        den = dw;
      end
      DIV_B: begin
        num = NumW'(ry_q) << Wf;
        den = yden;
      end
      default: begin
        num = '0;
        den = 11'd1;
      end
    endcase
  end

  irs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo),
    .rem_o   (rem)
  );

  assign sts_o.div_done = div_done;
  assign sts_o.run      = run;

  // neighbour positions and weights
  always_comb begin
    sw_lim = NumW'(sw);
    sh_lim = NumW'(sh);
    x1c = qx_q + NumW'(rx_q != '0);
    y1c = qy_q + NumW'(ry_q != '0);
    if (cfg_i.resize_method == MethodNearest) begin
      x0 = near_idx(qx_q, rx_q, dw, sw_lim);
      y0 = near_idx(qy_q, ry_q, yden, sh_lim);
      x1 = x0;
      y1 = y0;
      wa = '0;
      wb = '0;
    end else begin
      x0 = (qx_q > sw_lim - NumW'(1)) ? sw_lim - NumW'(1) : qx_q;
      y0 = (qy_q > sh_lim - NumW'(1)) ? sh_lim - NumW'(1) : qy_q;
      x1 = x1c;
      wa = a_q;
      if (x1c > sw_lim - NumW'(1)) begin
        x1 = sw_lim - NumW'(1);
        wa = '0;
      end
      y1 = y1c;
      wb = b_q;
      if (y1c > sh_lim - NumW'(1)) begin
        y1 = sh_lim - NumW'(1);
        wb = '0;
      end
    end
  end

  // read address and weight of one corner
  always_comb begin
    xs = cmd_i.rd_idx[0] ? x1_q : x0_q;
    ys = cmd_i.rd_idx[1] ? y1_q : y0_q;
    wx = cmd_i.rd_idx[0] ? {1'b0, wa_q} : One - {1'b0, wa_q};
    wy = cmd_i.rd_idx[1] ? {1'b0, wb_q} : One - {1'b0, wb_q};
    rd_addr_o = AddrW'(AddrW'(ys) * AddrW'(MAX_SRC_WIDTH) + AddrW'(xs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q <= col_i;
      row_q <= row_i;
    end
    if (cmd_i.div_latch) begin
      case (cmd_i.div_sel)
        DIV_H: dh_q <= (quo > NumW'(MaxDstSize)) ? 11'(MaxDstSize) : quo[10:0];
        DIV_X: begin
          qx_q <= quo;
          rx_q <= rem;
        end
        DIV_Y: begin
          qy_q <= quo;
          ry_q <= rem;
        end
        DIV_A: a_q <= quo[Wf-1:0];
        DIV_B: b_q <= quo[Wf-1:0];
        default: ;
      endcase
    end
    if (cmd_i.eval) begin
      run_q     <= run;
      outside_q <= outside;
    end
    if (cmd_i.prep) begin
      x0_q <= x0[XW-1:0];
      x1_q <= x1[XW-1:0];
      y0_q <= y0[YW-1:0];
      y1_q <= y1[YW-1:0];
      wa_q <= wa;
      wb_q <= wb;
      for (int k = 0; k < 3; k++) acc_q[k] <= '0;
    end
    if (cmd_i.rd_en) begin
      w_q <= PW'(wx * wy);
    end
    if (cmd_i.acc_en) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= acc_q[k] + AccW'(AccW'(rd_data_i[8*k +: 8]) * AccW'(w_q));
      end
    end
    if (cmd_i.finish) begin
      dest_col_q    <= col_q;
      dest_row_q    <= row_q;
      res_outside_q <= outside_q;
      ch_q[0] <= run_q ? acc_q[0][AccW-1 -: 8] : 8'd0;
      ch_q[1] <= (run_q && cfg_i.color_mode != ColorGray) ? acc_q[1][AccW-1 -: 8] : 8'd0;
      ch_q[2] <= (run_q && cfg_i.color_mode != ColorGray) ? acc_q[2][AccW-1 -: 8] : 8'd0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign dest_col_o  = dest_col_q;
  assign dest_row_o  = dest_row_q;
  assign out_ch0_o   = ch_q[0];
  assign out_ch1_o   = ch_q[1];
  assign out_ch2_o   = ch_q[2];
  assign outside_o   = res_outside_q;

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench of the image resize unit: fill, directed and random phases, checked against a predictor
`default_nettype none
module tb_top;
  import irs_pkg::*;

  typedef struct {
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic       outside;
  } pixel_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        command_i;
  logic [9:0]  col_i;
  logic [9:0]  row_i;
  logic [7:0]  pix_ch0_i;
  logic [7:0]  pix_ch1_i;
  logic [7:0]  pix_ch2_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [10:0] cfg_data_i;
  logic        res_valid_o;
  logic [9:0]  dest_col_o;
  logic [9:0]  dest_row_o;
  logic [7:0]  out_ch0_o;
  logic [7:0]  out_ch1_o;
  logic [7:0]  out_ch2_o;
  logic        outside_o;

  image_resize_nearest_bilinear_unit dut (.*);

  // rows loaded before any request, random source heights stay within them
  localparam int unsigned FillRows = 16;

  // predictor state
  logic [23:0]       frame_img [MaxSrcWidth*MaxSrcHeight];
  longint unsigned   src_w, src_h, dst_w, dst_h, keep_asp, method, colour;
  pixel_res_t        pending_pixels[$];
  int unsigned       n_errors;
  int unsigned       send_idle_pct;

  const int unsigned LdCmd  = 0;
  const int unsigned ReqCmd = 1;

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned round_even(longint unsigned q, longint unsigned r,
                                                 longint unsigned d, longint unsigned lim);
    longint unsigned t;
    t = 2 * r;
    if (t > d || (t == d && q[0])) q++;
    if (q > lim - 1) q = lim - 1;
    return q;
  endfunction

  function automatic logic [23:0] store_rd(longint unsigned x, longint unsigned y);
    longint unsigned a;
    a = y * MaxSrcWidth + x;
    if (a >= MaxSrcWidth * MaxSrcHeight) return '0;
    return frame_img[a];
  endfunction

  function automatic pixel_res_t resize_pixel(logic [9:0] col, logic [9:0] row);
    pixel_res_t r;
    longint unsigned sw, sh, dw, dh, yn, yd, qx, rx, qy, ry, x0, y0, x1, y1, a, b, acc;
    longint unsigned p00, p01, p10, p11, one;
    logic [23:0] p;
    r = '{col, row, 8'd0, 8'd0, 8'd0, 1'b0};
    sw = clamp_size(src_w, MaxSrcWidth);
    sh = clamp_size(src_h, MaxSrcHeight);
    dw = clamp_size(dst_w, MaxDstSize);
    if (keep_asp != 0) begin
      dh = dw * sh / sw;
      if (dh > MaxDstSize) dh = MaxDstSize;
      yn = sw; yd = dw;
    end else begin
      dh = clamp_size(dst_h, MaxDstSize);
      yn = sh; yd = dh;
    end
    r.outside = (col >= dw || row >= dh);
    if (!r.outside && colour <= ColorRgb && (method == MethodNearest || method == MethodBilinear)) begin
      qx = col * sw / dw; rx = col * sw % dw;
      qy = row * yn / yd; ry = row * yn % yd;
      if (method == MethodNearest) begin
        p = store_rd(round_even(qx, rx, dw, sw), round_even(qy, ry, yd, sh));
        r.ch0 = p[7:0]; r.ch1 = p[15:8]; r.ch2 = p[23:16];
      end else begin
        one = 1 << WeightFracBits;
        a = 0; b = 0;
        x0 = (qx > sw - 1) ? sw - 1 : qx;
        y0 = (qy > sh - 1) ? sh - 1 : qy;
        x1 = qx + (rx != 0);
        y1 = qy + (ry != 0);
        if (x1 > sw - 1) x1 = sw - 1;
        else a = (rx << WeightFracBits) / dw;
        if (y1 > sh - 1) y1 = sh - 1;
        else b = (ry << WeightFracBits) / yd;
        for (int k = 0; k < 3; k++) begin
          p00 = (store_rd(x0, y0) >> (8 * k)) & 8'hff;
          p01 = (store_rd(x1, y0) >> (8 * k)) & 8'hff;
          p10 = (store_rd(x0, y1) >> (8 * k)) & 8'hff;
          p11 = (store_rd(x1, y1) >> (8 * k)) & 8'hff;
          acc = p00 * (one - a) * (one - b) + p01 * a * (one - b) +
                p10 * (one - a) * b + p11 * a * b;
          acc = (acc >> (2 * WeightFracBits)) & 8'hff;
          if (k == 0) r.ch0 = acc[7:0];
          else if (k == 1) r.ch1 = acc[7:0];
          else r.ch2 = acc[7:0];
        end
      end
      if (colour == ColorGray) begin
        r.ch1 = '0; r.ch2 = '0;
      end
    end
    return r;
  endfunction

  task automatic send_word(int unsigned cmd, logic [9:0] col, logic [9:0] row,
                           logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd[0];
    col_i     <= col;
    row_i     <= row;
    pix_ch0_i <= c0;
    pix_ch1_i <= c1;
    pix_ch2_i <= c2;
    do @(posedge clk_i); while (busy);
    if (cmd == LdCmd) begin
      if (col < MaxSrcWidth && row < MaxSrcHeight) frame_img[row * MaxSrcWidth + col] = {c2, c1, c0};
    end else begin
      pending_pixels.push_back(resize_pixel(col, row));
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // valid stays high across back to back writes, the caller drops it
  task automatic write_reg(cfg_reg_e idx, logic [10:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SRC_WIDTH:     src_w = val & 11'h7f;
      REG_SRC_HEIGHT:    src_h = val & 11'h7f;
      REG_DST_WIDTH:     dst_w = val;
      REG_DST_HEIGHT:    dst_h = val;
      REG_KEEP_ASPECT:   keep_asp = val[0];
      REG_RESIZE_METHOD: method = val[1:0];
      REG_COLOR_MODE:    colour = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned sw, int unsigned sh, int unsigned dw, int unsigned dh,
                         int unsigned ka, int unsigned m, int unsigned c);
    drain();
    write_reg(REG_SRC_WIDTH, 11'(sw));
    write_reg(REG_SRC_HEIGHT, 11'(sh));
    write_reg(REG_DST_WIDTH, 11'(dw));
    write_reg(REG_DST_HEIGHT, 11'(dh));
    write_reg(REG_KEEP_ASPECT, 11'(ka));
    write_reg(REG_RESIZE_METHOD, 11'(m));
    write_reg(REG_COLOR_MODE, 11'(c));
    cfg_valid_i <= 1'b0;
  endtask

  // top rows loaded once so that no request reads an unloaded pixel
  task automatic test_fill;
    for (int y = 0; y < FillRows; y++)
      for (int x = 0; x < MaxSrcWidth; x++)
        send_word(LdCmd, 10'(x), 10'(y), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed;
    send_word(LdCmd, 0, 0, 8'hff, 8'h00, 8'hff);
    send_word(LdCmd, 63, 63, 8'h00, 8'hff, 8'h80);
    send_word(LdCmd, 64, 0, 8'h12, 8'h34, 8'h56);
    send_word(LdCmd, 10'h3ff, 10'h3ff, 8'hff, 8'hff, 8'hff);
    send_word(ReqCmd, 0, 0, 0, 0, 0);
    send_word(ReqCmd, 63, 63, 0, 0, 0);
    send_word(ReqCmd, 10'h3ff, 10'h3ff, 0, 0, 0);
    set_all(64, 64, 1024, 1024, 0, MethodBilinear, ColorRgb);
    send_word(ReqCmd, 1023, 1023, 0, 0, 0);
    send_word(ReqCmd, 517, 9, 0, 0, 0);
    set_all(1, 1, 1, 1, 0, MethodBilinear, ColorGray);
    send_word(ReqCmd, 0, 0, 0, 0, 0);
    send_word(ReqCmd, 1, 0, 0, 0, 0);
    // zero derived height with keep_aspect
    set_all(64, 1, 1, 5, 1, MethodNearest, ColorRgb);
    send_word(ReqCmd, 0, 0, 0, 0, 0);
    // saturated sizes
    set_all(0, 127, 2047, 0, 0, MethodNearest, ColorRgb);
    send_word(ReqCmd, 700, 0, 0, 0, 0);
    send_word(ReqCmd, 3, 1, 0, 0, 0);
    set_all(7, 64, 20, 3, 1, 0, ColorRgb);
    send_word(ReqCmd, 5, 5, 0, 0, 0);
    set_all(7, 5, 20, 3, 0, 3, ColorRgb);
    send_word(ReqCmd, 5, 1, 0, 0, 0);
    set_all(7, 5, 20, 13, 1, MethodBilinear, 2);
    send_word(ReqCmd, 19, 10, 0, 0, 0);
    set_all(7, 5, 20, 13, 0, MethodNearest, 3);
    send_word(ReqCmd, 10, 6, 0, 0, 0);
  endtask

  task automatic random_config;
    int unsigned sw, sh, dw, dh, m;
    sw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
    sh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, FillRows);
    dw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
    dh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 1024);
    m  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 2);
    set_all(sw, sh, dw, dh, $urandom_range(0, 1), m, $urandom_range(0, 3));
  endtask

  task automatic test_random(int unsigned n_words);
    longint unsigned dw, dh;
    logic [9:0] c, r;
    for (int i = 0; i < n_words; i++) begin
      if (i % 70 == 0) random_config();
      if ($urandom_range(0, 99) < 25) begin
        c = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63));
        r = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63));
        send_word(LdCmd, c, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        dw = clamp_size(dst_w, MaxDstSize);
        dh = (keep_asp != 0) ? dw * clamp_size(src_h, MaxSrcHeight) / clamp_size(src_w, MaxSrcWidth)
                             : clamp_size(dst_h, MaxDstSize);
        if (dh > MaxDstSize) dh = MaxDstSize;
        if (dh == 0) dh = 1;
        c = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, dw - 1));
        r = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, dh - 1));
        send_word(ReqCmd, c, r, 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    pixel_res_t e;
    if (rst_ni && res_valid_o) begin
      if (pending_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected pixel col %0d row %0d", $time, dest_col_o, dest_row_o);
      end else begin
        e = pending_pixels.pop_front();
        if (e.col !== dest_col_o || e.row !== dest_row_o || e.ch0 !== out_ch0_o ||
            e.ch1 !== out_ch1_o || e.ch2 !== out_ch2_o || e.outside !== outside_o) begin
          n_errors++;
          $display("%0t: expected %0d,%0d %h %h %h out %b actual %0d,%0d %h %h %h out %b",
                   $time, e.col, e.row, e.ch0, e.ch1, e.ch2, e.outside, dest_col_o,
                   dest_row_o, out_ch0_o, out_ch1_o, out_ch2_o, outside_o);
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0; command_i = 1'b0; col_i = '0; row_i = '0;
    pix_ch0_i = '0; pix_ch1_i = '0; pix_ch2_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    n_errors = 0;
    send_idle_pct = 29;
    src_w = 64; src_h = 64; dst_w = 64; dst_h = 64;
    keep_asp = 0; method = MethodNearest; colour = ColorRgb;
    foreach (frame_img[i]) frame_img[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill();
    test_directed();
    test_random(220);
    drain();
    send_idle_pct = 83;
    test_random(220);
    drain();
    send_idle_pct = 0;
    test_random(220);
    drain();
    repeat (150) @(posedge clk_i);
    if (n_errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #(12 * 2000000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
